[design/kvp_pkg.sv]
// ----------------------------------------------------------------------------
// kvp_pkg
// Shared types and byte constants for the key/value text line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package kvp_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_PATH  = 2'd1,
        MODE_KEY   = 2'd2,
        MODE_VALUE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } kind_t;

    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_SLASH  = 8'h2F;
    localparam logic [7:0] BYTE_EQ     = 8'h3D;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_N      = 8'h6E;
    localparam logic [7:0] BYTE_R      = 8'h72;

    // one parsed result item
    typedef struct packed {
        logic       store_entry;
        logic       token_nonempty;
        mode_t      section;
        kind_t      item_kind;
        logic [7:0] out_char;
    } result_t;

endpackage

`default_nettype wire

[design/kv_text_line_parser.sv]
// ----------------------------------------------------------------------------
// kv_text_line_parser
// Parses an escaped path / key=value text stream one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one raw byte per transfer in s_tdata; s_tlast high means
//   end of input (the line is flushed, s_tdata is ignored).
//   m_* channel gives at most one result per input byte: s_tdata-style char
//   in m_tdata, and kind, section and flags in m_tuser.
//   Bytes that give no result (leading slash, backslash) are dropped inside.
// Pipeline: the input register takes the byte at the transfer and the result
//   register loads from it when the result stage advances; the line state is
//   updated at that load too.
// Throughput: one byte per cycle, as long as a held result is not stalled
//   by m_tready being low.
// Reset: all registers empty, line state back to line start, no escape.
// Stall: when m_tready is low and a result is held, both stages hold and
//   s_tready drops once the input register is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_text_line_parser
    import kvp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_input
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic [5:0]      m_tuser    // [1:0] item_kind, [3:2] section,
                                       // [4] token_nonempty, [5] store_entry
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    mode_t      mode_reg, mode_next, mode_eff;
    logic       esc_reg, esc_next;
    logic       tok_reg, tok_next;
    logic       key_reg, key_next;

    logic       out_valid_reg;
    result_t    res_reg, res_next;
    logic       res_hit;
    logic       advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        tok_next  = tok_reg;
        key_next  = key_reg;
        res_hit   = 1'b0;
        res_next  = '0;
        mode_eff  = (mode_reg == MODE_START) ? MODE_KEY : mode_reg;

        if (in_eoi_reg || in_byte_reg == BYTE_LF || in_byte_reg == BYTE_CR)
        begin
            res_hit                 = 1'b1;
            res_next.item_kind      = KIND_LINE_END;
            res_next.section        = mode_reg;
            res_next.token_nonempty = tok_reg;
            res_next.store_entry    = (mode_reg == MODE_VALUE) && key_reg && tok_reg;
            mode_next = MODE_START;
            esc_next  = 1'b0;
            tok_next  = 1'b0;
            key_next  = 1'b0;
        end
        else if (mode_reg == MODE_START && in_byte_reg == BYTE_SLASH)
        begin
            mode_next = MODE_PATH;
        end
        else
        begin
            mode_next = mode_eff;
            if (esc_reg)
            begin
                // escaped byte is a character; an escaped n or r becomes LF or CR
                res_hit           = 1'b1;
                res_next.section  = mode_eff;
                res_next.item_kind = KIND_CHAR;
                if (in_byte_reg == BYTE_N)
                    res_next.out_char = BYTE_LF;
                else if (in_byte_reg == BYTE_R)
                    res_next.out_char = BYTE_CR;
                else
                    res_next.out_char = in_byte_reg;
                esc_next = 1'b0;
                tok_next = 1'b1;
            end
            else if (in_byte_reg == BYTE_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (mode_eff == MODE_PATH && in_byte_reg == BYTE_SLASH)
            begin
                res_hit                 = 1'b1;
                res_next.item_kind      = KIND_TOKEN_END;
                res_next.section        = MODE_PATH;
                res_next.token_nonempty = tok_reg;
                tok_next = 1'b0;
            end
            else if (mode_eff == MODE_KEY && in_byte_reg == BYTE_EQ)
            begin
                res_hit                 = 1'b1;
                res_next.item_kind      = KIND_TOKEN_END;
                res_next.section        = MODE_KEY;
                res_next.token_nonempty = tok_reg;
                key_next  = tok_reg;
                tok_next  = 1'b0;
                mode_next = MODE_VALUE;
            end
            else
            begin
                res_hit            = 1'b1;
                res_next.item_kind = KIND_CHAR;
                res_next.section   = mode_eff;
                res_next.out_char  = in_byte_reg;
                tok_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_START;
            esc_reg       <= 1'b0;
            tok_reg       <= 1'b0;
            key_reg       <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && res_hit;
                if (in_valid_reg)
                begin
                    mode_reg <= mode_next;
                    esc_reg  <= esc_next;
                    tok_reg  <= tok_next;
                    key_reg  <= key_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
        if (advance && in_valid_reg && res_hit)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg.out_char;
    assign m_tuser  = {res_reg.store_entry, res_reg.token_nonempty,
                       res_reg.section, res_reg.item_kind};

endmodule

`default_nettype wire

[design/kvp_checker.sv]
// ----------------------------------------------------------------------------
// kvp_checker
// Port-level checks on the key/value text line parser result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kvp_checker
    import kvp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [5:0] m_tuser
);

    // held result must not change while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only char, token end and line end are produced
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == KIND_CHAR || m_tuser[1:0] == KIND_TOKEN_END
                      || m_tuser[1:0] == KIND_LINE_END))
        else $error("bad item kind");

    // marks carry no character
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != KIND_CHAR |-> m_tdata == 8'h00)
        else $error("mark carries character");

    // store only on a value line end with a non-empty value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[5] |-> m_tuser[1:0] == KIND_LINE_END
                                   && m_tuser[3:2] == MODE_VALUE && m_tuser[4])
        else $error("store flag on wrong item");

    // characters never carry the non-empty flag or the start section
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == KIND_CHAR |-> !m_tuser[4] && m_tuser[3:2] != MODE_START)
        else $error("bad flags on character");

endmodule

bind kv_text_line_parser kvp_checker u_kvp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[verif/tb_kv_text_line_parser.sv]
// ----------------------------------------------------------------------------
// tb_kv_text_line_parser
// Self-checking bench for the path / key=value line parser: a directed table
// of lines, then random lines (most well formed with random content, the rest
// noise); results are checked against typed-in rows or a line-state predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_kv_text_line_parser;
    import kvp_pkg::*;

    localparam int RUN_LIMIT      = 600000;
    localparam int RANDOM_BYTES   = 1650;
    localparam int LINE_TABLE_LEN = 25;

    // one input transfer, with an optional typed-in expectation
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;
        logic       fixed_emit;
        result_t    fixed_res;
    } xfer_t;

    localparam result_t NO_RES   = '{1'b0, 1'b0, MODE_START, KIND_CHAR, 8'h00};
    localparam result_t LE_EMPTY = '{1'b0, 1'b0, MODE_START, KIND_LINE_END, 8'h00};

    localparam xfer_t LINE_TABLE [LINE_TABLE_LEN] = '{
        '{BYTE_LF,     1'b0, 1'b1, 1'b1, LE_EMPTY}, // empty line right after reset
        '{8'hFF,       1'b1, 1'b1, 1'b1, LE_EMPTY}, // end of input on empty line
        '{BYTE_SLASH,  1'b0, 1'b1, 1'b0, NO_RES},   // leading slash is dropped
        '{8'h61,       1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_SLASH,  1'b0, 1'b0, 1'b0, NO_RES},   // segment end
        '{BYTE_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_SLASH,  1'b0, 1'b0, 1'b0, NO_RES},   // escaped slash is a char
        '{BYTE_CR,     1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00,       1'b0, 1'b0, 1'b0, NO_RES},   // byte zero counts as a char
        '{BYTE_EQ,     1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_EQ,     1'b0, 1'b0, 1'b0, NO_RES},   // second '=' goes to the value
        '{BYTE_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_N,      1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_R,      1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_LF,     1'b0, 1'b0, 1'b0, NO_RES},   // entry to store
        '{BYTE_EQ,     1'b0, 1'b0, 1'b0, NO_RES},   // empty key
        '{8'hFF,       1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_LF,     1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_LF,     1'b0, 1'b0, 1'b0, NO_RES},   // line end drops pending escape
        '{8'h6B,       1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},
        '{BYTE_BSLASH, 1'b0, 1'b0, 1'b0, NO_RES},   // escaped backslash
        '{8'h61,       1'b1, 1'b0, 1'b0, NO_RES}    // end of input flushes key line
    };

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [5:0] m_tuser;

    xfer_t   stim_q [$];
    result_t parsed_q [$];
    int      n_accepted = 0;
    int      n_bad      = 0;
    int      cyc        = 0;
    int      sink_hold  = 0;

    // predicted line state
    mode_t   pm_mode = MODE_START;
    bit      pm_esc  = 1'b0;
    bit      pm_tok  = 1'b0;
    bit      pm_key  = 1'b0;

    wire calm = (cyc % 400) < 80;

    kv_text_line_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit parse_byte(input logic [7:0] b, input logic eoi,
                                      output result_t res);
        res = '0;
        if (eoi || b == BYTE_LF || b == BYTE_CR)
        begin
            res.item_kind      = KIND_LINE_END;
            res.section        = pm_mode;
            res.token_nonempty = pm_tok;
            res.store_entry    = (pm_mode == MODE_VALUE) && pm_key && pm_tok;
            pm_mode = MODE_START;
            pm_esc  = 1'b0;
            pm_tok  = 1'b0;
            pm_key  = 1'b0;
            return 1'b1;
        end
        if (pm_mode == MODE_START)
        begin
            if (b == BYTE_SLASH)
            begin
                pm_mode = MODE_PATH;
                return 1'b0;
            end
            pm_mode = MODE_KEY;
        end
        if (pm_esc)
        begin
            res.item_kind = KIND_CHAR;
            res.section   = pm_mode;
            res.out_char  = (b == BYTE_N) ? BYTE_LF : (b == BYTE_R) ? BYTE_CR : b;
            pm_esc = 1'b0;
            pm_tok = 1'b1;
            return 1'b1;
        end
        if (b == BYTE_BSLASH)
        begin
            pm_esc = 1'b1;
            return 1'b0;
        end
        if (pm_mode == MODE_PATH && b == BYTE_SLASH)
        begin
            res.item_kind      = KIND_TOKEN_END;
            res.section        = MODE_PATH;
            res.token_nonempty = pm_tok;
            pm_tok = 1'b0;
            return 1'b1;
        end
        if (pm_mode == MODE_KEY && b == BYTE_EQ)
        begin
            res.item_kind      = KIND_TOKEN_END;
            res.section        = MODE_KEY;
            res.token_nonempty = pm_tok;
            pm_key  = pm_tok;
            pm_tok  = 1'b0;
            pm_mode = MODE_VALUE;
            return 1'b1;
        end
        res.item_kind = KIND_CHAR;
        res.section   = pm_mode;
        res.out_char  = b;
        pm_tok = 1'b1;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        stim_q.push_back('{b, last, 1'b0, 1'b0, NO_RES});
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == BYTE_LF || b == BYTE_CR)
            b = ~b;
        return b;
    endfunction

    // one character of line content, escapes and separators mixed in
    task automatic push_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            push_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
        else if (r < 60)
            push_byte(plain_byte(), 1'b0);
        else if (r < 72)
        begin
            push_byte(BYTE_BSLASH, 1'b0);
            case ($urandom_range(0, 5))
                0:       push_byte(BYTE_N, 1'b0);
                1:       push_byte(BYTE_R, 1'b0);
                2:       push_byte(BYTE_SLASH, 1'b0);
                3:       push_byte(BYTE_EQ, 1'b0);
                4:       push_byte(BYTE_BSLASH, 1'b0);
                default: push_byte(plain_byte(), 1'b0);
            endcase
        end
        else if (r < 80)
            push_byte(BYTE_EQ, 1'b0);
        else if (r < 88)
            push_byte(BYTE_SLASH, 1'b0);
        else
            push_byte(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
    endtask

    task automatic push_line_end();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            push_byte(BYTE_LF, 1'b0);
        else if (r < 80)
            push_byte(BYTE_CR, 1'b0);
        else
            push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic push_noise();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 6))
                0:       b = BYTE_LF;
                1:       b = BYTE_CR;
                2:       b = BYTE_SLASH;
                3:       b = BYTE_EQ;
                4:       b = BYTE_BSLASH;
                5:       b = BYTE_N;
                default: b = BYTE_R;
            endcase
        end
        else
            b = 8'($urandom_range(0, 255));
        push_byte(b, $urandom_range(0, 11) == 0);
    endtask

    task automatic push_random_line();
        int r;
        int len;
        int nseg;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            len = $urandom_range(0, 5);
            repeat (len) push_text();
            push_byte(BYTE_EQ, 1'b0);
            len = $urandom_range(0, 8);
            repeat (len) push_text();
            push_line_end();
        end
        else if (r < 70)
        begin
            push_byte(BYTE_SLASH, 1'b0);
            nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg; s++)
            begin
                len = $urandom_range(0, 4);
                repeat (len) push_text();
                if (s < nseg - 1)
                    push_byte(BYTE_SLASH, 1'b0);
            end
            push_line_end();
        end
        else if (r < 85)
        begin
            len = $urandom_range(1, 6);
            repeat (len) push_text();
            push_line_end();
        end
        else if (r < 92)
            push_line_end();
        else
        begin
            len = $urandom_range(1, 12);
            repeat (len) push_noise();
        end
    endtask

    // check results, then predict on each accepted input transfer
    always @(posedge clk)
    begin : scoreboard
        result_t got;
        result_t want;
        result_t pred;
        bit      emit;
        xfer_t   row;
        if (m_tvalid && m_tready)
        begin
            got = result_t'({m_tuser, m_tdata});
            if (parsed_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: char=%02h kind=%0d sec=%0d ne=%0b st=%0b",
                             got.out_char, got.item_kind, got.section,
                             got.token_nonempty, got.store_entry);
            end
            else
            begin
                want = parsed_q.pop_front();
                if (got.out_char !== want.out_char || got.item_kind !== want.item_kind ||
                    got.section !== want.section ||
                    got.token_nonempty !== want.token_nonempty ||
                    got.store_entry !== want.store_entry)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: exp char=%02h kind=%0d sec=%0d ne=%0b st=%0b",
                                 want.out_char, want.item_kind, want.section,
                                 want.token_nonempty, want.store_entry,
                                 ", got char=%02h kind=%0d sec=%0d ne=%0b st=%0b",
                                 got.out_char, got.item_kind, got.section,
                                 got.token_nonempty, got.store_entry);
                end
            end
        end
        if (s_tvalid && s_tready)
        begin
            row  = stim_q[n_accepted];
            emit = parse_byte(s_tdata, s_tlast, pred);
            if (row.fixed)
            begin
                if (row.fixed_emit)
                    parsed_q.push_back(row.fixed_res);
            end
            else if (emit)
                parsed_q.push_back(pred);
            n_accepted++;
        end
    end

    // sink side pacing
    always @(posedge clk)
    begin : sink_pacing
        int r;
        if (sink_hold > 0)
            sink_hold <= sink_hold - 1;
        else if (calm)
            m_tready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                m_tready  <= 1'b1;
                sink_hold <= $urandom_range(0, 7);
            end
            else if (r < 92)
            begin
                m_tready  <= 1'b0;
                sink_hold <= $urandom_range(0, 2);
            end
            else
            begin
                m_tready  <= 1'b0;
                sink_hold <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == RUN_LIMIT)
        begin
            $display("kv_text_line_parser test failed");
            $finish;
        end
    end

    initial
    begin
        int gap;
        foreach (LINE_TABLE[i])
            stim_q.push_back(LINE_TABLE[i]);
        while (stim_q.size() < LINE_TABLE_LEN + RANDOM_BYTES)
            push_random_line();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int idx = 0; idx < stim_q.size(); idx++)
        begin
            // hold off until the parser has drained everything
            if (idx == LINE_TABLE_LEN || (idx > LINE_TABLE_LEN && idx % 500 == 0))
            begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (n_accepted != idx || parsed_q.size() != 0);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stim_q[idx].data;
            s_tlast  <= stim_q[idx].last;
            do @(posedge clk); while (!s_tready);
        end
        s_tvalid <= 1'b0;

        while (n_accepted != stim_q.size() || parsed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (n_bad == 0 && parsed_q.size() == 0)
            $display("kv_text_line_parser test passed");
        else
            $display("kv_text_line_parser test failed");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/kvp_pkg.sv
design/kv_text_line_parser.sv
design/kvp_checker.sv
verif/tb_kv_text_line_parser.sv
